### rtl/pfxe_pkg.sv
// Package for the prefix expression evaluator: value widths, character
// codes, error codes, sequencer states and the shared adder request type.
// No dependencies; the ALU and top-level files refer to it by scoped names.
package pfxe_pkg;

  // Fixed field and datapath widths
  localparam int VAL_W   = 48;  // signed fixed-point value
  localparam int ALU_W   = 52;  // shared adder width
  localparam int QUO_W   = 51;  // quotient/product magnitude before saturation
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;

  // Magnitude limits for saturation
  localparam logic [QUO_W-1:0] MAG_POS_LIM = {{(QUO_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] MAG_NEG_LIM = {{(QUO_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [QUO_W-1:0] QUO_BIG     = {2'b01, {(QUO_W-2){1'b0}}};

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_FULL      = 3'd2,
    ERR_DIV_ZERO  = 3'd3,
    ERR_SAT       = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH,
    ST_DIG_MUL,
    ST_DIG_ADD,
    ST_OP_RD,
    ST_OP_EXEC,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

### rtl/pfxe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the value stack.
module pfxe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pfxe_alu.sv
// Shared add/subtract unit of the evaluator datapath.
// Depends on pfxe_pkg for the request type and width.
module pfxe_alu (
  input  pfxe_pkg::alu_req_t          req_i,
  output logic [pfxe_pkg::ALU_W-1:0]  sum_o
);

  logic [pfxe_pkg::ALU_W-1:0] b_opnd;

  // Invert and carry in for subtraction
  assign b_opnd = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o  = req_i.a + b_opnd + {{(pfxe_pkg::ALU_W-1){1'b0}}, req_i.sub};

endmodule

### rtl/prefix_expression_evaluator_top.sv
// Prefix expression evaluator: sequencer and datapath around one shared adder.
// A pending number is pushed first. * runs 48 shift-add steps and / runs 48+FRAC_BITS restoring
// steps; underflow and divide by zero skip the operation. Input stalls while an item is in work,
// a stalled result holds the sequencer, and the next transaction is taken while the result is
// shown at the outputs. Reset clears stack pointer, number state and output valid.
module prefix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pfxe_pkg::CHAR_W-1:0]         char_code_i,
  input  logic                                expression_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pfxe_pkg::VAL_W-1:0]   top_value_o,
  output logic [pfxe_pkg::COUNT_W-1:0]        stack_count_o,
  output logic [pfxe_pkg::ERR_W-1:0]          error_code_o,
  output logic                                expression_done_o
);

  localparam int VW        = pfxe_pkg::VAL_W;
  localparam int AW        = pfxe_pkg::ALU_W;
  localparam int QW        = pfxe_pkg::QUO_W;
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W    = $clog2(STACK_DEPTH);
  localparam int DIV_STEPS = VW + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [VW-1:0] NUM_MAX     = VW'(48'h7FFF_FFFF_FFFF >> FRAC_BITS);
  localparam logic [VW-1:0] NUM_MAX_D10 = NUM_MAX / 10;
  localparam logic [VW-1:0] PLACE_LIM   = NUM_MAX + 48'd1;

  function automatic logic [AW-1:0] sext(input logic [VW-1:0] v);
    return {{(AW-VW){v[VW-1]}}, v};
  endfunction

  function automatic logic [AW-1:0] zext(input logic [VW-1:0] v);
    return {{(AW-VW){1'b0}}, v};
  endfunction

  function automatic pfxe_pkg::err_e raise(input pfxe_pkg::err_e cur,
                                           input pfxe_pkg::err_e code);
    return (cur == pfxe_pkg::ERR_NONE) ? code : cur;
  endfunction

  // Control state
  pfxe_pkg::state_e state_q, state_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [VW-1:0]    acc_q, acc_d;
  logic [VW-1:0]    place_q, place_d;
  logic             pending_q, pending_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Payload and working registers
  pfxe_pkg::err_e          err_q, err_d;
  logic [pfxe_pkg::CHAR_W-1:0] char_q, char_d;
  logic                    end_q, end_d;
  logic signed [VW-1:0]    top_q, top_d;
  logic [VW-1:0]           mag_a_q, mag_a_d;
  logic [VW-1:0]           mag_b_q, mag_b_d;
  logic                    neg_q, neg_d;
  logic [2*VW-1:0]         prod_q, prod_d;
  logic [AW-1:0]           dig_prod_q, dig_prod_d;
  logic [VW-1:0]           num_q, num_d;
  logic [VW-1:0]           rem_q, rem_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic                    big_q, big_d;
  logic [VW-1:0]           res_q, res_d;
  logic signed [VW-1:0]    out_top_q, out_top_d;
  logic [pfxe_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  pfxe_pkg::err_e          out_err_q, out_err_d;
  logic                    out_done_q, out_done_d;

  // Shared adder and stack memory
  pfxe_pkg::alu_req_t alu_req;
  logic [AW-1:0]      alu_sum;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [VW-1:0]      ram_wdata, ram_rdata;

  pfxe_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  pfxe_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic            in_acc;
  logic            out_load;
  logic            is_op;
  logic [SP_W-1:0] sp_m2;
  logic [3:0]      digit;
  logic [VW-1:0]   a_u;
  logic [VW-1:0]   b_u;
  logic [VW-1:0]   rs_low;
  logic [VW:0]     rs;
  logic            ge;
  logic [2*VW-1:0] prod_sh;
  logic [QW-1:0]   mag_sel;
  logic            big_sel;
  logic [VW:0]     mul_upper;
  logic            add_ovf;

  assign in_stall_o = (state_q != pfxe_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == pfxe_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);
  assign is_op      = (char_q == pfxe_pkg::CH_PLUS) || (char_q == pfxe_pkg::CH_MINUS) ||
                      (char_q == pfxe_pkg::CH_STAR) || (char_q == pfxe_pkg::CH_SLASH);
  assign sp_m2      = sp_q - SP_W'(2);
  assign digit      = char_q[3:0];
  assign a_u        = top_q;
  assign b_u        = ram_rdata;
  assign rs_low     = rem_q;
  assign rs         = {rs_low, num_q[VW-1]};
  assign ge         = !alu_sum[AW-1];
  assign prod_sh    = prod_q >> FRAC_BITS;
  assign mul_upper  = prod_q[0] ? alu_sum[VW:0] : {1'b0, prod_q[2*VW-1:VW]};
  assign add_ovf    = !((&alu_sum[AW-1:VW-1]) || (~|alu_sum[AW-1:VW-1]));

  // Pick the magnitude to saturate: product or quotient
  always_comb begin
    if (char_q == pfxe_pkg::CH_STAR) begin
      mag_sel = prod_sh[QW-1:0];
      big_sel = |prod_sh[2*VW-1:QW];
    end else begin
      mag_sel = quo_q;
      big_sel = big_q;
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    acc_d       = acc_q;
    place_d     = place_q;
    pending_d   = pending_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    char_d      = char_q;
    end_d       = end_q;
    top_d       = top_q;
    mag_a_d     = mag_a_q;
    mag_b_d     = mag_b_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    dig_prod_d  = dig_prod_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    big_d       = big_q;
    res_d       = res_q;
    out_top_d   = out_top_q;
    out_count_d = out_count_q;
    out_err_d   = out_err_q;
    out_done_d  = out_done_q;
    alu_req     = '{sub: 1'b0, a: '0, b: '0};
    ram_we      = 1'b0;
    ram_waddr   = sp_q[ADDR_W-1:0];
    ram_wdata   = acc_q << FRAC_BITS;
    ram_re      = 1'b0;
    ram_raddr   = sp_m2[ADDR_W-1:0];

    // Drop a taken result
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      pfxe_pkg::ST_IDLE: begin
        if (in_acc) begin
          char_d  = char_code_i;
          end_d   = expression_end_i;
          err_d   = pfxe_pkg::ERR_NONE;
          state_d = pfxe_pkg::ST_DECODE;
        end
      end

      pfxe_pkg::ST_DECODE: begin
        unique case (char_q) inside
          pfxe_pkg::CH_SPACE, pfxe_pkg::CH_PLUS, pfxe_pkg::CH_MINUS,
          pfxe_pkg::CH_STAR, pfxe_pkg::CH_SLASH: begin
            if (pending_q) begin
              state_d = pfxe_pkg::ST_FLUSH;
            end else if (is_op) begin
              state_d = pfxe_pkg::ST_OP_RD;
            end else begin
              state_d = pfxe_pkg::ST_OUT;
            end
          end
          [pfxe_pkg::CH_ZERO:pfxe_pkg::CH_NINE]: begin
            state_d = pfxe_pkg::ST_DIG_MUL;
          end
          default: begin
            // Restart the number at zero
            acc_d     = '0;
            place_d   = VW'(1);
            pending_d = 1'b1;
            state_d   = end_q ? pfxe_pkg::ST_FLUSH : pfxe_pkg::ST_OUT;
          end
        endcase
      end

      pfxe_pkg::ST_FLUSH: begin
        // Push the pending number, drop it when the stack is full
        if (sp_q >= SP_W'(STACK_DEPTH)) begin
          err_d = raise(err_q, pfxe_pkg::ERR_FULL);
        end else begin
          ram_we = 1'b1;
          top_d  = ram_wdata;
          sp_d   = sp_q + SP_W'(1);
        end
        acc_d     = '0;
        place_d   = VW'(1);
        pending_d = 1'b0;
        state_d   = is_op ? pfxe_pkg::ST_OP_RD : pfxe_pkg::ST_OUT;
      end

      pfxe_pkg::ST_DIG_MUL: begin
        dig_prod_d = AW'(digit) * zext(place_q);
        big_d      = place_q > NUM_MAX;
        place_d    = (place_q > NUM_MAX_D10) ? PLACE_LIM : ((place_q << 3) + (place_q << 1));
        pending_d  = 1'b1;
        state_d    = pfxe_pkg::ST_DIG_ADD;
      end

      pfxe_pkg::ST_DIG_ADD: begin
        alu_req = '{sub: 1'b0, a: zext(acc_q), b: dig_prod_q};
        if (digit != 4'd0) begin
          if (big_q || (alu_sum > zext(NUM_MAX))) begin
            acc_d = NUM_MAX;
            err_d = raise(err_q, pfxe_pkg::ERR_SAT);
          end else begin
            acc_d = alu_sum[VW-1:0];
          end
        end
        state_d = end_q ? pfxe_pkg::ST_FLUSH : pfxe_pkg::ST_OUT;
      end

      pfxe_pkg::ST_OP_RD: begin
        // Fetch the second operand; the top sits in a register
        if (sp_q < SP_W'(2)) begin
          err_d   = raise(err_q, pfxe_pkg::ERR_UNDERFLOW);
          state_d = pfxe_pkg::ST_OUT;
        end else begin
          ram_re  = 1'b1;
          state_d = pfxe_pkg::ST_OP_EXEC;
        end
      end

      pfxe_pkg::ST_OP_EXEC: begin
        mag_a_d = a_u[VW-1] ? (~a_u + VW'(1)) : a_u;
        mag_b_d = b_u[VW-1] ? (~b_u + VW'(1)) : b_u;
        neg_d   = a_u[VW-1] ^ b_u[VW-1];
        cnt_d   = '0;
        unique case (char_q) inside
          pfxe_pkg::CH_PLUS, pfxe_pkg::CH_MINUS: begin
            alu_req = '{sub: (char_q == pfxe_pkg::CH_MINUS), a: sext(a_u), b: sext(b_u)};
            if (add_ovf) begin
              res_d = alu_sum[AW-1] ? pfxe_pkg::VAL_MIN : pfxe_pkg::VAL_MAX;
              err_d = raise(err_q, pfxe_pkg::ERR_SAT);
            end else begin
              res_d = alu_sum[VW-1:0];
            end
            state_d = pfxe_pkg::ST_WRITE;
          end
          pfxe_pkg::CH_STAR: begin
            prod_d  = {{VW{1'b0}}, (b_u[VW-1] ? (~b_u + VW'(1)) : b_u)};
            state_d = pfxe_pkg::ST_MUL;
          end
          default: begin
            if (b_u == '0) begin
              err_d   = raise(err_q, pfxe_pkg::ERR_DIV_ZERO);
              state_d = pfxe_pkg::ST_OUT;
            end else begin
              num_d   = a_u[VW-1] ? (~a_u + VW'(1)) : a_u;
              rem_d   = '0;
              quo_d   = '0;
              big_d   = 1'b0;
              state_d = pfxe_pkg::ST_DIV;
            end
          end
        endcase
      end

      pfxe_pkg::ST_MUL: begin
        // One shift-add step per cycle
        alu_req = '{sub: 1'b0, a: zext(prod_q[2*VW-1:VW]), b: zext(mag_a_q)};
        prod_d  = {mul_upper, prod_q[VW-1:1]};
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VW - 1)) begin
          state_d = pfxe_pkg::ST_SAT;
        end
      end

      pfxe_pkg::ST_DIV: begin
        // One restoring step per cycle; freeze the quotient once too large
        alu_req = '{sub: 1'b1, a: {{(AW-VW-1){1'b0}}, rs}, b: zext(mag_b_q)};
        rem_d   = ge ? alu_sum[VW-1:0] : rs[VW-1:0];
        num_d   = num_q << 1;
        if (quo_q > pfxe_pkg::QUO_BIG) begin
          big_d = 1'b1;
        end else begin
          quo_d = {quo_q[QW-2:0], ge};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = pfxe_pkg::ST_SAT;
        end
      end

      pfxe_pkg::ST_SAT: begin
        if (neg_q) begin
          if (big_sel || (mag_sel > pfxe_pkg::MAG_NEG_LIM)) begin
            res_d = pfxe_pkg::VAL_MIN;
            err_d = raise(err_q, pfxe_pkg::ERR_SAT);
          end else begin
            res_d = ~mag_sel[VW-1:0] + VW'(1);
          end
        end else begin
          if (big_sel || (mag_sel > pfxe_pkg::MAG_POS_LIM)) begin
            res_d = pfxe_pkg::VAL_MAX;
            err_d = raise(err_q, pfxe_pkg::ERR_SAT);
          end else begin
            res_d = mag_sel[VW-1:0];
          end
        end
        state_d = pfxe_pkg::ST_WRITE;
      end

      pfxe_pkg::ST_WRITE: begin
        // Replace the two operands by the result
        ram_we    = 1'b1;
        ram_waddr = sp_m2[ADDR_W-1:0];
        ram_wdata = res_q;
        top_d     = res_q;
        sp_d      = sp_q - SP_W'(1);
        state_d   = pfxe_pkg::ST_OUT;
      end

      pfxe_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_top_d   = (sp_q != '0) ? top_q : '0;
          out_count_d = pfxe_pkg::COUNT_W'(sp_q);
          out_err_d   = err_q;
          out_done_d  = end_q;
          if (end_q) begin
            sp_d      = '0;
            acc_d     = '0;
            place_d   = VW'(1);
            pending_d = 1'b0;
          end
          state_d = pfxe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pfxe_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfxe_pkg::ST_IDLE;
      sp_q        <= '0;
      acc_q       <= '0;
      place_q     <= VW'(1);
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      acc_q       <= acc_d;
      place_q     <= place_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    char_q      <= char_d;
    end_q       <= end_d;
    top_q       <= top_d;
    mag_a_q     <= mag_a_d;
    mag_b_q     <= mag_b_d;
    neg_q       <= neg_d;
    prod_q      <= prod_d;
    dig_prod_q  <= dig_prod_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    big_q       <= big_d;
    res_q       <= res_d;
    out_top_q   <= out_top_d;
    out_count_q <= out_count_d;
    out_err_q   <= out_err_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o       = out_valid_q;
  assign top_value_o       = out_top_q;
  assign stack_count_o     = out_count_q;
  assign error_code_o      = out_err_q;
  assign expression_done_o = out_done_q;

  // Stack pointer never runs past the depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // A push is written only when there is room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfxe_pkg::ST_FLUSH && ram_we) |-> (sp_q < SP_W'(STACK_DEPTH)))
    else $error("push written into a full stack");

  // A flush always consumes the pending number
  a_flush_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfxe_pkg::ST_FLUSH) |=> !pending_q)
    else $error("pending number survived a flush");

  // The end of an expression clears the stack and the number
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && end_q) |=> (sp_q == '0 && !pending_q && acc_q == '0))
    else $error("expression end did not clear state");

endmodule
